// File: rtl/core/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Used by skt_cell, skt_chain, sorted_key_table and tb; depends on nothing.
package skt_pkg;

    localparam int CAPACITY          = 64;
    localparam int KEY_BITS          = 13;
    localparam int PAYLOAD_BITS      = 16;
    localparam int COUNT_BITS        = $clog2(CAPACITY + 1);
    localparam int KIND_BITS         = 2;
    localparam int STATUS_BITS       = 2;
    localparam int ENTRY_COUNT_BITS  = 7;
    localparam int FIND_SUM_BITS     = 16;
    localparam int S_TDATA_BITS      = 48;
    localparam int M_TDATA_BITS      = 24;
    localparam int DAY_FACTOR        = 30;
    localparam int HOUR_FACTOR       = 5;

    typedef enum logic [KIND_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

// File: rtl/core/sorted_key_table.sv
// Top level of the sorted key table: stream ports, operation sequencing,
// entry count and result register; uses skt_pkg and skt_chain.
//
// The table keeps up to 64 entries (key and payload) in ascending key order.
// Each input item on the s_ channel is an operation chosen by s_tuser: insert
// (placed after any equal keys, or status full), find by date (key formed as
// (day*30+hour)*5+month), delete of the first entry with the key, or no-op.
// Every item yields exactly one result item on the m_ channel with a status,
// the found or removed payload and the entry count after the operation.
// An item is accepted in ST_IDLE, or in ST_APPLY as the previous result is
// loaded; in ST_CMP every cell compares its key in parallel and registers the
// outcome; in ST_APPLY the cells shift toward or away from the insert or
// delete point and the result is loaded into the output register.
// So a new item is accepted no earlier than the load of the last result.
// The output register holds a result while m_tready is low; the block keeps
// the finished compare waiting and stops accepting items until it frees up.
// Reset clears the table to empty, the count to zero and both channels.
module sorted_key_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // kind[1:0]
    input  logic [skt_pkg::KIND_BITS-1:0]       s_tuser,
    // key[12:0], payload_in[28:13], month[31:29], day[36:32], hour[41:37], zero fill
    input  logic [skt_pkg::S_TDATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0]
    output logic [skt_pkg::STATUS_BITS-1:0]     m_tuser,
    // payload_out[15:0], entry_count[22:16], zero fill
    output logic [skt_pkg::M_TDATA_BITS-1:0]    m_tdata
);
    import skt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    state_t                  state_reg;
    op_t                     op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    m_tvalid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic [PAYLOAD_BITS-1:0] result_payload;

    logic [KEY_BITS-1:0]      in_key;
    logic [PAYLOAD_BITS-1:0]  in_payload;
    logic [2:0]               in_month;
    logic [4:0]               in_day;
    logic [4:0]               in_hour;
    logic [FIND_SUM_BITS-1:0] find_sum;
    logic [KEY_BITS-1:0]      op_key_in;

    logic                    can_apply;
    logic                    apply;
    logic                    accept;
    logic                    full;
    logic                    hit;
    logic [PAYLOAD_BITS-1:0] hit_payload;
    cell_ctrl_t              ctrl;

    assign in_key     = s_tdata[12:0];
    assign in_payload = s_tdata[28:13];
    assign in_month   = s_tdata[31:29];
    assign in_day     = s_tdata[36:32];
    assign in_hour    = s_tdata[41:37];

    assign find_sum = (FIND_SUM_BITS'(in_day) * FIND_SUM_BITS'(DAY_FACTOR)
                       + FIND_SUM_BITS'(in_hour)) * FIND_SUM_BITS'(HOUR_FACTOR)
                      + FIND_SUM_BITS'(in_month);
    assign op_key_in = (op_t'(s_tuser) == OP_FIND) ? find_sum[KEY_BITS-1:0] : in_key;

    assign can_apply = !m_tvalid_reg || m_tready;
    assign apply     = (state_reg == ST_APPLY) && can_apply;
    assign s_tready  = aresetn && ((state_reg == ST_IDLE) || apply);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == COUNT_BITS'(CAPACITY));

    always_comb begin
        ctrl.cmp = (state_reg == ST_CMP);
        ctrl.ins = apply && (op_reg == OP_INSERT) && !full;
        ctrl.del = apply && (op_reg == OP_DELETE);
    end

    skt_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .op_key      (key_reg),
        .op_payload  (payload_reg),
        .hit         (hit),
        .hit_payload (hit_payload)
    );

    always_comb begin
        status_next    = STATUS_DONE;
        result_payload = '0;
        count_next     = count_reg;
        unique case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    result_payload = hit_payload;
                end else begin
                    status_next = STATUS_MISSING;
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    result_payload = hit_payload;
                    count_next     = count_reg - 1'b1;
                end else begin
                    status_next = STATUS_MISSING;
                end
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            status_reg   <= STATUS_DONE;
            m_tdata_reg  <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (apply) begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= status_next;
                        m_tdata_reg  <= {1'b0, ENTRY_COUNT_BITS'(count_next), result_payload};
                        state_reg    <= accept ? ST_CMP : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= op_t'(s_tuser);
            key_reg     <= op_key_in;
            payload_reg <= in_payload;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/skt_cell.sv
// One slot of the sorted key table: holds a key, a payload and a valid bit.
// Compares against the operation key and shifts with its neighbors; uses skt_pkg.
module skt_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  skt_pkg::cell_ctrl_t            ctrl,
    input  logic [skt_pkg::KEY_BITS-1:0]     op_key,
    input  logic [skt_pkg::PAYLOAD_BITS-1:0] op_payload,
    input  logic [skt_pkg::KEY_BITS-1:0]     left_key,
    input  logic [skt_pkg::PAYLOAD_BITS-1:0] left_payload,
    input  logic                           left_valid,
    input  logic                           left_after,
    input  logic                           left_ge,
    input  logic [skt_pkg::KEY_BITS-1:0]     right_key,
    input  logic [skt_pkg::PAYLOAD_BITS-1:0] right_payload,
    input  logic                           right_valid,
    output logic [skt_pkg::KEY_BITS-1:0]     key,
    output logic [skt_pkg::PAYLOAD_BITS-1:0] payload,
    output logic                           valid,
    output logic                           after,
    output logic                           ge,
    output logic                           first_hit
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic                    valid_reg;
    logic                    gt_reg;
    logic                    ge_reg;
    logic                    eq_reg;
    logic                    take_ins;
    logic                    take_del;

    assign after     = gt_reg || !valid_reg;
    assign ge        = ge_reg;
    assign first_hit = eq_reg && !left_ge;
    assign key       = key_reg;
    assign payload   = payload_reg;
    assign valid     = valid_reg;
    assign take_ins  = ctrl.ins && after;
    assign take_del  = ctrl.del && ge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            if (ctrl.cmp) begin
                gt_reg <= valid_reg && (key_reg > op_key);
                ge_reg <= valid_reg && (key_reg >= op_key);
                eq_reg <= valid_reg && (key_reg == op_key);
            end
            if (take_ins) begin
                valid_reg <= left_after ? left_valid : 1'b1;
            end else if (take_del) begin
                valid_reg <= right_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_ins) begin
            key_reg     <= left_after ? left_key : op_key;
            payload_reg <= left_after ? left_payload : op_payload;
        end else if (take_del) begin
            key_reg     <= right_key;
            payload_reg <= right_payload;
        end
    end

endmodule

// File: rtl/core/skt_chain.sv
// Row of skt_cell slots kept in ascending key order, with the hit and
// payload pick for find and delete; uses skt_pkg and skt_cell.
module skt_chain (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  skt_pkg::cell_ctrl_t            ctrl,
    input  logic [skt_pkg::KEY_BITS-1:0]     op_key,
    input  logic [skt_pkg::PAYLOAD_BITS-1:0] op_payload,
    output logic                           hit,
    output logic [skt_pkg::PAYLOAD_BITS-1:0] hit_payload
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0]     key_w     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];
    logic [CAPACITY-1:0]     valid_w;
    logic [CAPACITY-1:0]     after_w;
    logic [CAPACITY-1:0]     ge_w;
    logic [CAPACITY-1:0]     first_w;
    cell_ctrl_t              cell_ctrl;

    always_comb begin
        cell_ctrl     = ctrl;
        cell_ctrl.del = ctrl.del && hit;
    end

    assign hit = |first_w;

    always_comb begin
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_payload = hit_payload | (payload_w[i] & {PAYLOAD_BITS{first_w[i]}});
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0]     l_key;
        logic [PAYLOAD_BITS-1:0] l_payload;
        logic                    l_valid;
        logic                    l_after;
        logic                    l_ge;
        logic [KEY_BITS-1:0]     r_key;
        logic [PAYLOAD_BITS-1:0] r_payload;
        logic                    r_valid;

        if (i == 0) begin : g_first
            assign l_key     = key_w[i];
            assign l_payload = payload_w[i];
            assign l_valid   = 1'b0;
            assign l_after   = 1'b0;
            assign l_ge      = 1'b0;
        end else begin : g_mid
            assign l_key     = key_w[i-1];
            assign l_payload = payload_w[i-1];
            assign l_valid   = valid_w[i-1];
            assign l_after   = after_w[i-1];
            assign l_ge      = ge_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_key     = key_w[i];
            assign r_payload = payload_w[i];
            assign r_valid   = 1'b0;
        end else begin : g_inner
            assign r_key     = key_w[i+1];
            assign r_payload = payload_w[i+1];
            assign r_valid   = valid_w[i+1];
        end

        skt_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (cell_ctrl),
            .op_key        (op_key),
            .op_payload    (op_payload),
            .left_key      (l_key),
            .left_payload  (l_payload),
            .left_valid    (l_valid),
            .left_after    (l_after),
            .left_ge       (l_ge),
            .right_key     (r_key),
            .right_payload (r_payload),
            .right_valid   (r_valid),
            .key           (key_w[i]),
            .payload       (payload_w[i]),
            .valid         (valid_w[i]),
            .after         (after_w[i]),
            .ge            (ge_w[i]),
            .first_hit     (first_w[i])
        );
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_table: drives insert, find, delete and no-op items
// on the s_ stream and checks every m_ result against a predictor of the sorted table.
// Depends on skt_pkg and the sorted_key_table RTL only.
module tb;
    import skt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        status_t                 status;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [6:0]              entry_count;
    } table_result_t;

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [KIND_BITS-1:0]    s_tuser  = '0;
    // key[12:0], payload_in[28:13], month[31:29], day[36:32], hour[41:37], zero fill
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [STATUS_BITS-1:0]  m_tuser;
    // payload_out[15:0], entry_count[22:16], zero fill
    logic [M_TDATA_BITS-1:0] m_tdata;

    logic [KEY_BITS-1:0]     table_keys [CAPACITY];
    logic [PAYLOAD_BITS-1:0] table_payloads [CAPACITY];
    int                      table_count = 0;
    table_result_t           pending_results [$];
    table_result_t           oldest_result;
    int                      error_count = 0;
    int                      cycle_count = 0;
    bit                      no_idle = 1'b0;

    sorted_key_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int locate_key(logic [KEY_BITS-1:0] k);
        int idx;
        idx = -1;
        for (int i = table_count - 1; i >= 0; i--) begin
            if (table_keys[i] == k) begin
                idx = i;
            end
        end
        return idx;
    endfunction

    function automatic table_result_t apply_table_op(op_t kind, logic [KEY_BITS-1:0] key,
                                                     logic [PAYLOAD_BITS-1:0] payload,
                                                     logic [2:0] month, logic [4:0] day,
                                                     logic [4:0] hour);
        table_result_t res;
        int pos;
        int date_sum;
        res.status  = STATUS_DONE;
        res.payload = '0;
        case (kind)
            OP_INSERT: begin
                if (table_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = table_count;
                    while (pos > 0 && table_keys[pos-1] > key) begin
                        table_keys[pos]     = table_keys[pos-1];
                        table_payloads[pos] = table_payloads[pos-1];
                        pos--;
                    end
                    table_keys[pos]     = key;
                    table_payloads[pos] = payload;
                    table_count++;
                end
            end
            OP_FIND: begin
                date_sum = (int'(day) * DAY_FACTOR + int'(hour)) * HOUR_FACTOR + int'(month);
                pos = locate_key(date_sum[KEY_BITS-1:0]);
                if (pos < 0) begin
                    res.status = STATUS_MISSING;
                end else begin
                    res.payload = table_payloads[pos];
                end
            end
            OP_DELETE: begin
                pos = locate_key(key);
                if (pos < 0) begin
                    res.status = STATUS_MISSING;
                end else begin
                    res.payload = table_payloads[pos];
                    for (int i = pos; i + 1 < table_count; i++) begin
                        table_keys[i]     = table_keys[i+1];
                        table_payloads[i] = table_payloads[i+1];
                    end
                    table_count--;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = table_count[6:0];
        return res;
    endfunction

    task automatic send_item(op_t kind, logic [KEY_BITS-1:0] key,
                             logic [PAYLOAD_BITS-1:0] payload, logic [2:0] month,
                             logic [4:0] day, logic [4:0] hour);
        while (!no_idle && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, hour, day, month, payload, key};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(apply_table_op(kind, key, payload, month, day, hour));
        @(negedge aclk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50 && table_count > 0) begin
            return table_keys[$urandom_range(table_count - 1)];
        end else if (roll < 70) begin
            return KEY_BITS'($urandom_range(15));
        end else if (roll < 85) begin
            return KEY_BITS'(($urandom_range(31) * DAY_FACTOR + $urandom_range(29))
                             * HOUR_FACTOR + $urandom_range(4));
        end
        return KEY_BITS'($urandom);
    endfunction

    task automatic send_random_items(int n_items, int insert_pct, int find_pct, int delete_pct);
        int roll;
        int kv;
        op_t kind;
        logic [KEY_BITS-1:0] key;
        logic [2:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            if (roll < insert_pct) begin
                kind = OP_INSERT;
            end else if (roll < insert_pct + find_pct) begin
                kind = OP_FIND;
            end else if (roll < insert_pct + find_pct + delete_pct) begin
                kind = OP_DELETE;
            end else begin
                kind = OP_NONE;
            end
            key   = pick_key();
            month = 3'($urandom);
            day   = 5'($urandom);
            hour  = 5'($urandom);
            if (kind == OP_FIND) begin
                roll = $urandom_range(99);
                if (roll < 60 && table_count > 0) begin
                    kv = int'(table_keys[$urandom_range(table_count - 1)]);
                    if (kv / (DAY_FACTOR * HOUR_FACTOR) < 32) begin
                        day   = 5'(kv / (DAY_FACTOR * HOUR_FACTOR));
                        hour  = 5'((kv / HOUR_FACTOR) % DAY_FACTOR);
                        month = 3'(kv % HOUR_FACTOR);
                    end
                end else if (roll < 85) begin
                    month = 3'($urandom_range(4));
                    day   = 5'($urandom_range(31));
                    hour  = 5'($urandom_range(29));
                end
            end
            send_item(kind, key, 16'($urandom), month, day, hour);
        end
    endtask

    task automatic test_empty_table();
        send_item(OP_FIND, 13'd0, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_DELETE, 13'd0, 16'hffff, 3'd7, 5'd31, 5'd31);
    endtask

    task automatic test_insert_order();
        send_item(OP_INSERT, 13'h1fff, 16'hffff, 3'd7, 5'd31, 5'd31);
        send_item(OP_INSERT, 13'd0, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_INSERT, 13'd100, 16'h1111, 3'd1, 5'd2, 5'd3);
        send_item(OP_INSERT, 13'd100, 16'h2222, 3'd4, 5'd5, 5'd6);
        send_item(OP_INSERT, 13'd50, 16'haaaa, 3'd2, 5'd9, 5'd29);
    endtask

    task automatic test_find_by_date();
        send_item(OP_INSERT, 13'd487, 16'h1234, 3'd0, 5'd0, 5'd0);
        send_item(OP_FIND, 13'd0, 16'h0000, 3'd2, 5'd3, 5'd7);
        send_item(OP_FIND, 13'h1fff, 16'hffff, 3'd0, 5'd0, 5'd0);
        send_item(OP_FIND, 13'd0, 16'h0000, 3'd7, 5'd31, 5'd31);
        send_item(OP_FIND, 13'd0, 16'h0000, 3'd0, 5'd0, 5'd20);
    endtask

    task automatic test_delete_positions();
        send_item(OP_DELETE, 13'd100, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_DELETE, 13'h1fff, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_DELETE, 13'd0, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_DELETE, 13'd100, 16'h0000, 3'd0, 5'd0, 5'd0);
        send_item(OP_DELETE, 13'd9, 16'h0000, 3'd0, 5'd0, 5'd0);
    endtask

    task automatic test_unused_kind();
        send_item(OP_NONE, 13'd487, 16'hffff, 3'd7, 5'd31, 5'd31);
        send_item(OP_FIND, 13'd0, 16'h0000, 3'd2, 5'd3, 5'd7);
    endtask

    task automatic test_fill_to_full();
        send_random_items(400, 70, 15, 10);
    endtask

    task automatic test_drain_to_empty();
        send_random_items(400, 15, 15, 65);
    endtask

    task automatic test_mixed_traffic();
        send_random_items(750, 40, 25, 30);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random_items(300, 40, 25, 30);
        no_idle = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d, data %h", $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_tuser !== oldest_result.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, oldest_result.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[15:0] !== oldest_result.payload) begin
                    $display("%0t: payload mismatch, expected %h, actual %h",
                             $time, oldest_result.payload, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[22:16] !== oldest_result.entry_count) begin
                    $display("%0t: entry count mismatch, expected %0d, actual %0d",
                             $time, oldest_result.entry_count, m_tdata[22:16]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_empty_table();
        test_insert_order();
        test_find_by_date();
        test_delete_positions();
        test_unused_kind();
        test_fill_to_full();
        test_drain_to_empty();
        test_mixed_traffic();
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: sorted_key_table.f
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/skt_chain.sv
rtl/core/sorted_key_table.sv
test/tb.sv
